// ===== hw/rtl/isa_pkg.sv =====
`timescale 1ns / 1ps

package isa_pkg;

  // Number of cells in the chain; the entry address is interleaved over them
  localparam int CellBits = 2;
  localparam int NumCells = 1 << CellBits;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SET  = 2'd2,
    OP_GET  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_e;

  // Control part of a token that travels down the cell chain
  typedef struct packed {
    logic                vld;
    logic                last;
    logic                wr;
    logic                rd;
    logic [CellBits-1:0] hop;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/indexed_stack_array_core.sv =====
`timescale 1ns / 1ps

// Fixed-capacity array with a fill count, usable as a stack (push, pop) and by
// index (set, get). Entries are interleaved over a chain of four cells, each
// holding one memory bank; a request travels down the chain one cell per
// cycle and the owning cell does the access. Push, pop, get and a set that
// needs no zero-fill are registered at the input transfer, issued as a token
// in ST_ISSUE and loaded into the output register once the token has left the
// last cell and the output is free; the controller then goes idle and accepts
// the next request, also while the result still waits to be taken. A set past
// the current count first zero-fills the gap (index minus count) one entry a cycle.
// Failed requests (push when full, pop when empty, index out of range) leave
// the state unchanged and report it in status. The array contents come out
// of reset undefined; only written entries are ever read.
module indexed_stack_array_core #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] data_o,
  output logic [10:0]        count_o,
  output logic               empty_res_o,
  output logic [1:0]         status_o
);
  import isa_pkg::*;

  localparam int BANK_DEPTH = (DEPTH + NumCells - 1) / NumCells;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  cell_ctl_t             ctl_c   [NumCells+1];
  logic [BANK_AW-1:0]    word_c  [NumCells+1];
  logic [DATA_WIDTH-1:0] wdata_c [NumCells+1];
  logic [DATA_WIDTH-1:0] rdata_c [NumCells+1];

  // Read data enters the chain empty
  assign rdata_c[0] = '0;

  isa_ctl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .tok_ctl_o    (ctl_c[0]),
    .tok_word_o   (word_c[0]),
    .tok_wdata_o  (wdata_c[0]),
    .done_ctl_i   (ctl_c[NumCells]),
    .done_rdata_i (rdata_c[NumCells]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_o       (data_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o),
    .status_o     (status_o)
  );

  // Chain of bank cells
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    isa_cell #(
      .BANK_DEPTH (BANK_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_c[k]),
      .word_i  (word_c[k]),
      .wdata_i (wdata_c[k]),
      .rdata_i (rdata_c[k]),
      .ctl_o   (ctl_c[k+1]),
      .word_o  (word_c[k+1]),
      .wdata_o (wdata_c[k+1]),
      .rdata_o (rdata_c[k+1])
    );
  end

endmodule

// ===== hw/rtl/isa_cell.sv =====
`timescale 1ns / 1ps

module isa_cell #(
  parameter int BANK_DEPTH = 256,
  parameter int DATA_WIDTH = 32,
  localparam int BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  isa_pkg::cell_ctl_t      ctl_i,
  input  logic [BANK_AW-1:0]      word_i,
  input  logic [DATA_WIDTH-1:0]   wdata_i,
  input  logic [DATA_WIDTH-1:0]   rdata_i,
  output isa_pkg::cell_ctl_t      ctl_o,
  output logic [BANK_AW-1:0]      word_o,
  output logic [DATA_WIDTH-1:0]   wdata_o,
  output logic [DATA_WIDTH-1:0]   rdata_o
);
  import isa_pkg::*;

  logic [DATA_WIDTH-1:0] mem [BANK_DEPTH];

  cell_ctl_t             ctl_d, ctl_q;
  logic                  sel;
  logic                  hit_q;
  logic [BANK_AW-1:0]    word_q;
  logic [DATA_WIDTH-1:0] wdata_q;
  logic [DATA_WIDTH-1:0] pass_q;
  logic [DATA_WIDTH-1:0] mem_rd_q;

  // This cell owns the token when its hop count has run down to zero
  assign sel = ctl_i.vld && (ctl_i.hop == '0);

  // Count the hop down for the next cell
  always_comb begin
    ctl_d     = ctl_i;
    ctl_d.hop = CellBits'(ctl_i.hop - 1'b1);
  end

  // Advance the token control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      hit_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      hit_q <= sel && ctl_i.rd;
    end
  end

  // Advance the token payload
  always_ff @(posedge clk_i) begin
    word_q  <= word_i;
    wdata_q <= wdata_i;
    pass_q  <= rdata_i;
  end

  // Access the local bank
  always_ff @(posedge clk_i) begin
    if (sel && ctl_i.wr) begin
      mem[word_i] <= wdata_i;
    end
    if (sel && ctl_i.rd) begin
      mem_rd_q <= mem[word_i];
    end
  end

  assign ctl_o   = ctl_q;
  assign word_o  = word_q;
  assign wdata_o = wdata_q;
  assign rdata_o = hit_q ? mem_rd_q : pass_q;

endmodule

// ===== hw/rtl/isa_ctl.sv =====
`timescale 1ns / 1ps

module isa_ctl #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32,
  localparam int AW         = $clog2(DEPTH),
  localparam int CW         = $clog2(DEPTH + 1),
  localparam int BANK_DEPTH = (DEPTH + isa_pkg::NumCells - 1) / isa_pkg::NumCells,
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic [9:0]              index_i,
  input  logic signed [31:0]      value_i,
  output isa_pkg::cell_ctl_t      tok_ctl_o,
  output logic [BANK_AW-1:0]      tok_word_o,
  output logic [DATA_WIDTH-1:0]   tok_wdata_o,
  input  isa_pkg::cell_ctl_t      done_ctl_i,
  input  logic [DATA_WIDTH-1:0]   done_rdata_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [31:0]      data_o,
  output logic [10:0]             count_o,
  output logic                    empty_res_o,
  output logic [1:0]              status_o
);
  import isa_pkg::*;

  state_e                state_q, state_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [AW-1:0]         req_addr_q;
  logic                  req_wr_q, req_rd_q;
  logic [DATA_WIDTH-1:0] req_wdata_q;
  logic [CW-1:0]         res_count_q;
  status_e               res_status_q;
  logic [DATA_WIDTH-1:0] res_data_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic [CW-1:0]         out_count_q;
  status_e               out_status_q;

  logic                  acc;
  op_e                   op;
  logic [31:0]           idx32, cnt32, nxt32, addr32;
  status_e               acc_status;
  logic                  acc_wr, acc_rd, acc_gap;
  logic [63:0]           val64, rd64;
  logic [31:0]           cnt_out32;
  logic                  done, out_free, load_out, capture_res;
  logic [DATA_WIDTH-1:0] load_data;
  logic [AW-1:0]         tok_addr;
  logic [AW+CellBits-1:0] addr_ext;

  assign acc      = in_valid_i && (state_q == ST_IDLE);
  assign op       = op_e'(opcode_i);
  assign idx32    = {22'b0, index_i};
  assign cnt32    = 32'(fill_q);
  assign val64    = {32'b0, value_i};
  assign done     = done_ctl_i.vld && done_ctl_i.last;
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode the request against the current fill count
  always_comb begin
    acc_status = STAT_OK;
    acc_wr     = 1'b0;
    acc_rd     = 1'b0;
    acc_gap    = 1'b0;
    nxt32      = cnt32;
    addr32     = idx32;
    unique case (op)
      OP_PUSH: begin
        if (cnt32 >= 32'(DEPTH)) begin
          acc_status = STAT_FULL;
        end else begin
          acc_wr = 1'b1;
          addr32 = cnt32;
          nxt32  = cnt32 + 32'd1;
        end
      end
      OP_POP: begin
        if (cnt32 == 32'd0) begin
          acc_status = STAT_EMPTY;
        end else begin
          acc_rd = 1'b1;
          addr32 = cnt32 - 32'd1;
          nxt32  = cnt32 - 32'd1;
        end
      end
      OP_SET: begin
        if (idx32 >= 32'(DEPTH)) begin
          acc_status = STAT_RANGE;
        end else begin
          acc_wr = 1'b1;
          if (idx32 >= cnt32) begin
            nxt32   = idx32 + 32'd1;
            acc_gap = (idx32 > cnt32);
          end
        end
      end
      OP_GET: begin
        if (idx32 >= cnt32) begin
          acc_status = STAT_RANGE;
        end else begin
          acc_rd = 1'b1;
        end
      end
      default: begin
        acc_status = STAT_RANGE;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = acc_gap ? ST_FILL : ST_ISSUE;
        end
      end
      ST_FILL: begin
        if (AW'(clr_q + 1'b1) == req_addr_q) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) begin
          state_d = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs: tokens into the chain and result hand-off
  always_comb begin
    tok_ctl_o   = '0;
    tok_addr    = req_addr_q;
    tok_wdata_o = req_wdata_q;
    load_out    = 1'b0;
    load_data   = done_rdata_i;
    capture_res = 1'b0;
    clr_d       = clr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          clr_d = cnt32[AW-1:0];
        end
      end
      ST_FILL: begin
        tok_ctl_o.vld = 1'b1;
        tok_ctl_o.wr  = 1'b1;
        tok_addr      = clr_q;
        tok_wdata_o   = '0;
        clr_d         = AW'(clr_q + 1'b1);
      end
      ST_ISSUE: begin
        tok_ctl_o.vld  = 1'b1;
        tok_ctl_o.last = 1'b1;
        tok_ctl_o.wr   = req_wr_q;
        tok_ctl_o.rd   = req_rd_q;
      end
      ST_WAIT: begin
        load_out    = done && out_free;
        capture_res = done && !out_free;
      end
      ST_DONE: begin
        load_out  = out_free;
        load_data = res_data_q;
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
    tok_ctl_o.hop = addr_ext[CellBits-1:0];
  end

  // Split the entry address into cell select and bank word
  assign addr_ext   = {CellBits'(0), tok_addr};
  assign tok_word_o = addr_ext[BANK_AW+CellBits-1:CellBits];

  assign fill_d = acc ? nxt32[CW-1:0] : fill_q;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      clr_q   <= clr_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_addr_q   <= addr32[AW-1:0];
      req_wr_q     <= acc_wr;
      req_rd_q     <= acc_rd;
      req_wdata_q  <= val64[DATA_WIDTH-1:0];
      res_count_q  <= nxt32[CW-1:0];
      res_status_q <= acc_status;
    end
    if (capture_res) begin
      res_data_q <= done_rdata_i;
    end
    if (load_out) begin
      out_data_q   <= load_data;
      out_count_q  <= res_count_q;
      out_status_q <= res_status_q;
    end
  end

  assign rd64      = 64'(out_data_q);
  assign cnt_out32 = 32'(out_count_q);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_o      = rd64[31:0];
  assign count_o     = cnt_out32[10:0];
  assign empty_res_o = (out_count_q == '0);
  assign status_o    = out_status_q;

endmodule
